/* design/prw_pkg.sv */
// Package for the Prewitt gradient magnitude block.
// Holds size defaults, register indexes, field widths and the square-root step.
// No dependencies.
package prw_pkg;

  // Default sizes of the line memory and the frame.
  localparam int MaxLineLenDefault = 1024;
  localparam int MaxLinesDefault   = 1024;

  // Field widths of the ports.
  localparam int PixelW = 8;
  localparam int CfgW   = 11;
  localparam int PosW   = 10;

  // Configuration register indexes.
  localparam logic CfgLineLength = 1'b0;
  localparam logic CfgLineCount  = 1'b1;

  // Register values after reset.
  localparam logic [CfgW-1:0] CfgResetValue = 11'd1024;

  // Partial remainder and root of the digit-by-digit square root.
  typedef struct packed {
    logic [15:0] rem;
    logic [15:0] root;
  } sqrt_acc_t;

  // One result bit of the floor square root; weight is the current power of four.
  function automatic sqrt_acc_t sqrt_step(sqrt_acc_t acc, logic [15:0] weight);
    sqrt_acc_t   nxt;
    logic [16:0] trial;
    trial = {1'b0, acc.root} + {1'b0, weight};
    if ({1'b0, acc.rem} >= trial) begin
      nxt.rem  = acc.rem - trial[15:0];
      nxt.root = (acc.root >> 1) + weight;
    end else begin
      nxt.rem  = acc.rem;
      nxt.root = acc.root >> 1;
    end
    return nxt;
  endfunction

endpackage

/* design/prewitt_gradient_magnitude.sv */
// Top level of the Prewitt gradient magnitude block.
// Depends on prw_pkg for sizes, register indexes and the square-root step.

// Takes 8-bit gray pixels in raster order and gives, for every interior pixel,
// the floor of sqrt(gx^2 + gy^2) of the 3x3 Prewitt gradients, saturated at 255,
// with the center position and a mark on the last result of the frame. Border
// pixels give no result. The two lines above the current one sit in one
// 16-bit-wide line memory with a registered read, so each pixel is read, then
// written back in the next cycle. An interior pixel goes through the steps
// read, gradient and write-back, squaring, the square-root unit at two result
// bits per cycle, and output load, which waits while the output register is
// still full and not taken. The next pixel is accepted once the previous one
// is done: a border pixel after its write-back, an interior one once it has
// left for the output register. Line length and line count are clamped to
// [3, MAX_LINE_LEN] and [3, MAX_LINES] and should be written between frames.
module prewitt_gradient_magnitude #(
  parameter int MAX_LINE_LEN = prw_pkg::MaxLineLenDefault,
  parameter int MAX_LINES    = prw_pkg::MaxLinesDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_index_i,
  input  logic [prw_pkg::CfgW-1:0]    cfg_data_i,
  // Pixel input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [prw_pkg::PixelW-1:0]  pixel_i,
  // Result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [prw_pkg::PixelW-1:0]  magnitude_o,
  output logic [prw_pkg::PosW-1:0]    center_line_o,
  output logic [prw_pkg::PosW-1:0]    center_column_o,
  output logic                        frame_last_o
);
  import prw_pkg::*;

  localparam int AddrW = $clog2(MAX_LINE_LEN);
  localparam int LenW  = AddrW + 1;
  localparam int LineW = $clog2(MAX_LINES);
  localparam int CntW  = LineW + 1;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_SQUARE = 3'd2;
  localparam logic [2:0] S_ROOT   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CfgW-1:0]   cfg_len_q, cfg_cnt_q;
  logic [AddrW-1:0]  col_q;
  logic [LineW-1:0]  line_q;
  logic [PixelW-1:0] win_q [6];

  // Line memory: upper byte is the line two above, lower byte the line above.
  logic [2*PixelW-1:0] line_mem [MAX_LINE_LEN];
  logic [2*PixelW-1:0] rd_q;
  logic [PixelW-1:0]   pix_q;

  logic signed [10:0] gx_q, gy_q;
  logic [PosW-1:0]    cl_q, cc_q;
  logic               last_q;
  logic               sat_q;
  sqrt_acc_t          acc_q;
  logic [1:0]         step_q;

  logic               out_valid_q;
  logic [PixelW-1:0]  mag_q;
  logic [PosW-1:0]    out_line_q, out_col_q;
  logic               out_last_q;

  logic in_acc;
  logic out_load;

  // Handshakes.
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Effective frame size after clamping.
  logic [LenW-1:0] len_eff;
  logic [CntW-1:0] cnt_eff;
  always_comb begin
    if (cfg_len_q < 11'd3) begin
      len_eff = LenW'(3);
    end else if (32'(cfg_len_q) > 32'(MAX_LINE_LEN)) begin
      len_eff = LenW'(MAX_LINE_LEN);
    end else begin
      len_eff = LenW'(cfg_len_q);
    end
    if (cfg_cnt_q < 11'd3) begin
      cnt_eff = CntW'(3);
    end else if (32'(cfg_cnt_q) > 32'(MAX_LINES)) begin
      cnt_eff = CntW'(MAX_LINES);
    end else begin
      cnt_eff = CntW'(cfg_cnt_q);
    end
  end

  // Window columns around the pixel being processed.
  logic [PixelW-1:0] top, mid, bot;
  assign top = rd_q[2*PixelW-1:PixelW];
  assign mid = rd_q[PixelW-1:0];
  assign bot = pix_q;

  // Prewitt gradients: right column minus left, bottom row minus top.
  logic [9:0] sum_r, sum_l, sum_b, sum_t;
  logic signed [10:0] gx_d, gy_d;
  assign sum_r = 10'(top) + 10'(mid) + 10'(bot);
  assign sum_l = 10'(win_q[0]) + 10'(win_q[1]) + 10'(win_q[2]);
  assign sum_b = 10'(win_q[2]) + 10'(win_q[5]) + 10'(bot);
  assign sum_t = 10'(win_q[0]) + 10'(win_q[3]) + 10'(top);
  assign gx_d  = signed'({1'b0, sum_r}) - signed'({1'b0, sum_l});
  assign gy_d  = signed'({1'b0, sum_b}) - signed'({1'b0, sum_t});

  // Position bookkeeping.
  logic            produce;
  logic [LenW-1:0] col_next;
  logic [CntW-1:0] line_next;
  logic            frame_end;
  assign produce   = (32'(line_q) >= 32'd2) && (32'(col_q) >= 32'd2);
  assign col_next  = LenW'(col_q) + LenW'(1);
  assign line_next = CntW'(line_q) + CntW'(1);
  assign frame_end = (CntW'(line_q) == cnt_eff - CntW'(1))
                  && (LenW'(col_q) == len_eff - LenW'(1));

  // Sum of squares.
  logic signed [21:0] gx_sq, gy_sq;
  logic [20:0]        sq_sum;
  assign gx_sq  = gx_q * gx_q;
  assign gy_sq  = gy_q * gy_q;
  assign sq_sum = 21'(gx_sq) + 21'(gy_sq);

  // Two root bits per cycle.
  logic [15:0] w_hi, w_lo;
  assign w_hi = 16'h4000 >> {step_q, 2'b00};
  assign w_lo = w_hi >> 2;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_acc) state_d = S_READ;
      S_READ:   state_d = produce ? S_SQUARE : S_IDLE;
      S_SQUARE: state_d = S_ROOT;
      S_ROOT:   if (step_q == 2'd3) state_d = S_DONE;
      S_DONE:   if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Control state, configuration, counters and the window.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_len_q   <= CfgResetValue;
      cfg_cnt_q   <= CfgResetValue;
      col_q       <= '0;
      line_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgLineLength: cfg_len_q <= cfg_data_i;
          CfgLineCount:  cfg_cnt_q <= cfg_data_i;
          default:       cfg_len_q <= cfg_len_q;
        endcase
      end
      if (state_q == S_READ) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= top;
        win_q[4] <= mid;
        win_q[5] <= bot;
        if (col_next >= len_eff) begin
          col_q <= '0;
          if (line_next >= cnt_eff) begin
            line_q <= '0;
          end else begin
            line_q <= LineW'(line_next);
          end
        end else begin
          col_q <= AddrW'(col_next);
        end
      end
      if (state_q == S_SQUARE) begin
        step_q <= '0;
      end else if (state_q == S_ROOT) begin
        step_q <= step_q + 2'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Line memory: read on accept, write back the shifted column in the next cycle.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= line_mem[col_q];
    end
    if (state_q == S_READ) begin
      line_mem[col_q] <= {mid, bot};
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_q <= pixel_i;
    end
    if (state_q == S_READ) begin
      gx_q   <= gx_d;
      gy_q   <= gy_d;
      cl_q   <= PosW'(32'(line_q) - 32'd1);
      cc_q   <= PosW'(32'(col_q) - 32'd1);
      last_q <= frame_end;
    end
    if (state_q == S_SQUARE) begin
      sat_q <= |sq_sum[20:16];
      acc_q <= '{rem: sq_sum[15:0], root: 16'd0};
    end else if (state_q == S_ROOT) begin
      acc_q <= sqrt_step(sqrt_step(acc_q, w_hi), w_lo);
    end
    if (out_load) begin
      mag_q      <= sat_q ? 8'd255 : acc_q.root[PixelW-1:0];
      out_line_q <= cl_q;
      out_col_q  <= cc_q;
      out_last_q <= last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign magnitude_o     = mag_q;
  assign center_line_o   = out_line_q;
  assign center_column_o = out_col_q;
  assign frame_last_o    = out_last_q;

  // A memory read-back cycle always follows an accepted item.
  a_read_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> $past(in_valid_i) && $past(state_q) == S_IDLE)
    else $error("line memory read-back without an accepted item");

  // The column counter never leaves the line memory.
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < 32'(MAX_LINE_LEN))
    else $error("column counter beyond line memory depth");

  // The root unit always starts from its first step.
  a_root_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SQUARE |=> state_q == S_ROOT && step_q == 2'd0)
    else $error("square-root unit did not start at its first step");

  // A new result is only loaded from the finished state.
  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_DONE)
    else $error("result loaded outside the finished state");

endmodule

/* tb/sv/prewitt_magnitude_checker.sv */
`timescale 1ns / 100ps
// Result checker for the Prewitt gradient magnitude block.
// Watches the register, pixel and result channels and predicts every result.
// Depends on prw_pkg for field widths, register indexes and size defaults.
module prewitt_magnitude_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic                        cfg_index_i,
  input  logic [prw_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [prw_pkg::PixelW-1:0]  pixel_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [prw_pkg::PixelW-1:0]  magnitude_i,
  input  logic [prw_pkg::PosW-1:0]    center_line_i,
  input  logic [prw_pkg::PosW-1:0]    center_column_i,
  input  logic                        frame_last_i,
  output int                          pending_o,
  output int                          fail_count_o
);
  import prw_pkg::*;

  localparam int LineMemDepth = MaxLineLenDefault;

  typedef struct packed {
    logic [PixelW-1:0] magnitude;
    logic [PosW-1:0]   center_line;
    logic [PosW-1:0]   center_column;
    logic              frame_last;
  } gradient_t;

  // Own copy of the line memories, the window and the raster position.
  logic [PixelW-1:0] older_line [LineMemDepth];
  logic [PixelW-1:0] upper_line [LineMemDepth];
  logic [PixelW-1:0] window [6];
  int unsigned       line_at;
  int unsigned       column_at;
  logic [CfgW-1:0]   length_reg;
  logic [CfgW-1:0]   count_reg;

  gradient_t         due_gradients [$];
  gradient_t         oldest;
  int                mismatches;
  int                k;

  function automatic int unsigned clamp_size(logic [CfgW-1:0] raw, int unsigned hi);
    if (raw < 3) return 3;
    if (raw > hi) return hi;
    return raw;
  endfunction

  // Floor square root, saturated at 255, one result bit at a time.
  function automatic logic [PixelW-1:0] floor_root(int unsigned sq);
    int unsigned root;
    int unsigned trial;
    if (sq >= 255 * 255) return 8'hFF;
    root = 0;
    for (int b = 7; b >= 0; b--) begin
      trial = root | (1 << b);
      if (trial * trial <= sq) root = trial;
    end
    return 8'(root);
  endfunction

  // Moves one pixel through the line memories and the window, and queues a
  // result when the pixel completes an interior neighborhood.
  task automatic take_pixel(input logic [PixelW-1:0] px);
    int unsigned len, cnt, col, row, idx, sq;
    int          top, mid, bot, gx, gy;
    gradient_t   g;
    len = clamp_size(length_reg, LineMemDepth);
    cnt = clamp_size(count_reg, MaxLinesDefault);
    col = column_at;
    row = line_at;
    idx = col % LineMemDepth;
    bot = int'(px);
    top = int'(older_line[idx]);
    mid = int'(upper_line[idx]);
    if (row >= 2 && col >= 2) begin
      gx = (top + mid + bot) - (int'(window[0]) + int'(window[1]) + int'(window[2]));
      gy = (int'(window[2]) + int'(window[5]) + bot)
         - (int'(window[0]) + int'(window[3]) + top);
      sq = gx * gx + gy * gy;
      g.magnitude     = floor_root(sq);
      g.center_line   = PosW'(row - 1);
      g.center_column = PosW'(col - 1);
      g.frame_last    = (row == cnt - 1) && (col == len - 1);
      due_gradients.push_back(g);
    end
    older_line[idx] = 8'(mid);
    upper_line[idx] = px;
    window[0] = window[3];
    window[1] = window[4];
    window[2] = window[5];
    window[3] = 8'(top);
    window[4] = 8'(mid);
    window[5] = px;
    col++;
    if (col >= len) begin
      col = 0;
      row++;
      if (row >= cnt) row = 0;
    end
    column_at = col;
    line_at   = row;
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Register writes, accepted pixels and taken results, in that order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (k = 0; k < LineMemDepth; k++) begin
        older_line[k] = '0;
        upper_line[k] = '0;
      end
      for (k = 0; k < 6; k++) window[k] = '0;
      line_at      = 0;
      column_at    = 0;
      length_reg   = CfgResetValue;
      count_reg    = CfgResetValue;
      mismatches   = 0;
      due_gradients.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgLineLength: length_reg = cfg_data_i;
          CfgLineCount:  count_reg  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) take_pixel(pixel_i);
      if (out_valid_i && out_ready_i) begin
        if (due_gradients.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, expected none, actual %0d at (%0d, %0d)",
                   $time, magnitude_i, center_line_i, center_column_i);
        end else begin
          oldest = due_gradients.pop_front();
          compare_field("magnitude", oldest.magnitude, magnitude_i);
          compare_field("center_line", oldest.center_line, center_line_i);
          compare_field("center_column", oldest.center_column, center_column_i);
          compare_field("frame_last", oldest.frame_last, frame_last_i);
        end
      end
      pending_o    <= due_gradients.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Top of the testbench for the Prewitt gradient magnitude block.
// Makes pixel frames and register writes, takes results and gives the verdict.
// Depends on prw_pkg, prewitt_gradient_magnitude and prewitt_magnitude_checker.
module tb_top;
  import prw_pkg::*;

  localparam int CycleLimit      = 1_000_000;
  localparam int SettleCycles    = 16;
  localparam int SmallFrameItems = 900;
  localparam int LongHoldCycles  = 300;

  typedef enum {TextureUniform, TextureExtremes, TextureSmooth, TextureFlat} texture_e;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic              cfg_index_i;
  logic [CfgW-1:0]   cfg_data_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [PixelW-1:0] pixel_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [PixelW-1:0] magnitude_o;
  logic [PosW-1:0]   center_line_o;
  logic [PosW-1:0]   center_column_o;
  logic              frame_last_o;
  int                pending;
  int                fail_count;
  int                cycle_count;

  // Raster position and sizes as the sender sees them.
  int unsigned       len_eff;
  int unsigned       cnt_eff;
  int unsigned       col_at;
  int unsigned       line_at;
  bit                in_steady;

  prewitt_gradient_magnitude DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .pixel_i         (pixel_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .magnitude_o     (magnitude_o),
    .center_line_o   (center_line_o),
    .center_column_o (center_column_o),
    .frame_last_o    (frame_last_o)
  );

  prewitt_magnitude_checker u_gradient_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .pixel_i         (pixel_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .magnitude_i     (magnitude_o),
    .center_line_i   (center_line_o),
    .center_column_i (center_column_o),
    .frame_last_i    (frame_last_o),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case results never arrive.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int unsigned clamp_size(logic [CfgW-1:0] raw, int unsigned hi);
    if (raw < 3) return 3;
    if (raw > hi) return hi;
    return raw;
  endfunction

  // Wait before an item; now and then switch between idling and back-to-back.
  function automatic int pick_gap(inout bit steady);
    if ($urandom_range(0, 39) == 0) steady = !steady;
    return steady ? 0 : int'($urandom_range(0, 11));
  endfunction

  // Mostly small sizes, sometimes below the minimum or somewhat larger.
  function automatic logic [CfgW-1:0] draw_extent(int unsigned usual_max);
    case ($urandom_range(0, 9))
      0:       return CfgW'($urandom_range(0, 2));
      1:       return CfgW'($urandom_range(usual_max + 1, 2 * usual_max));
      default: return CfgW'($urandom_range(3, usual_max));
    endcase
  endfunction

  function automatic logic [PixelW-1:0] textured_pixel(texture_e texture,
                                                        logic [PixelW-1:0] base);
    case (texture)
      TextureExtremes: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      TextureSmooth:   return (base & 8'hFC) | 8'($urandom_range(0, 3));
      TextureFlat:     return base;
      default:         return 8'($urandom);
    endcase
  endfunction

  // Offer one pixel and wait until the block takes it.
  task automatic send_pixel(input logic [PixelW-1:0] value);
    int gap;
    gap = pick_gap(in_steady);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i    <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    col_at++;
    if (col_at >= len_eff) begin
      col_at = 0;
      line_at++;
      if (line_at >= cnt_eff) line_at = 0;
    end
  endtask

  // Stop offering pixels until every expected result is out and the block is quiet.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic index, input logic [CfgW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (index == CfgLineLength) len_eff = clamp_size(value, MaxLineLenDefault);
    else cnt_eff = clamp_size(value, MaxLinesDefault);
  endtask

  task automatic set_size(input logic [CfgW-1:0] length, input logic [CfgW-1:0] count);
    drain();
    write_reg(CfgLineLength, length);
    write_reg(CfgLineCount, count);
    cfg_valid_i <= 1'b0;
  endtask

  // Result side: random stalls, steady stretches and a few long hold-offs.
  initial begin : result_sink
    int gap;
    int taken;
    bit steady;
    out_ready_i = 1'b0;
    taken       = 0;
    steady      = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (taken == 25 || (taken > 25 && $urandom_range(0, 599) == 0)) gap = LongHoldCycles;
      else gap = pick_gap(steady);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      taken++;
    end
  end

  initial begin : stimulus
    int          r;
    int          c;
    int          fed;
    int          cut_after;
    int          small_items;
    texture_e    texture;
    logic [7:0]  base;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    pixel_i     = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgLineLength;
    cfg_data_i  = '0;
    in_steady   = 1'b0;
    len_eff     = MaxLineLenDefault;
    cnt_eff     = MaxLinesDefault;
    col_at      = 0;
    line_at     = 0;
    small_items = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sizes below the minimum clamp to a 3x3 frame; a flat bright frame gives zero.
    set_size(CfgW'(0), CfgW'(2));
    repeat (9) send_pixel(8'hFF);

    // A bright corner edge drives the magnitude into saturation.
    for (r = 0; r < 3; r++)
      for (c = 0; c < 3; c++)
        send_pixel((r == 2 || c == 2) ? 8'hFF : 8'h00);

    // Line length shrinks in the middle of a line: the column wraps and the
    // frame ends without a last mark.
    set_size(CfgW'(4), CfgW'(3));
    repeat (11) send_pixel(8'($urandom));
    set_size(CfgW'(3), CfgW'(3));
    send_pixel(8'($urandom));

    // Tallest frame, cut short by lowering the line count mid-frame.
    set_size(CfgW'(3), CfgW'(2047));
    repeat (36) send_pixel(8'($urandom));
    set_size(CfgW'(3), CfgW'(3));
    do send_pixel(8'($urandom)); while (col_at != 0 || line_at != 0);

    // A wide frame, run to its last result.
    set_size(CfgW'(300), CfgW'(0));
    do send_pixel(8'($urandom)); while (col_at != 0 || line_at != 0);

    // Random small frames with varied texture, some resized mid-frame.
    while (small_items < SmallFrameItems) begin
      if (small_items == 0 || $urandom_range(0, 1) == 1)
        set_size(draw_extent(12), draw_extent(8));
      texture   = texture_e'($urandom_range(0, 3));
      base      = 8'($urandom);
      cut_after = 0;
      if ($urandom_range(0, 5) == 0)
        cut_after = int'($urandom_range(1, len_eff * cnt_eff - 1));
      fed = 0;
      do begin
        send_pixel(textured_pixel(texture, base));
        fed++;
        small_items++;
        // Only shrink the line length mid-frame, so no unwritten memory is read.
        if (fed == cut_after)
          set_size(CfgW'($urandom_range(0, len_eff)), CfgW'($urandom_range(0, 12)));
      end while (col_at != 0 || line_at != 0);
    end

    drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/prw_pkg.sv
design/prewitt_gradient_magnitude.sv
tb/sv/prewitt_magnitude_checker.sv
tb/sv/tb_top.sv
